/* design/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define VPA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define VPA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/vpa_pkg.sv */
// Shared types and codes of the variable partition allocator.
package vpa_pkg;

    typedef logic [1:0]  t_op;
    typedef logic [1:0]  t_status;
    typedef logic [7:0]  t_owner;
    typedef logic [1:0]  t_cfg_idx;
    typedef logic [15:0] t_cfg_data;

    localparam t_op OP_BEST  = 2'd0;
    localparam t_op OP_WORST = 2'd1;
    localparam t_op OP_FIRST = 2'd2;
    localparam t_op OP_FREE  = 2'd3;

    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_NOFIT = 2'd1;
    localparam t_status ST_FULL  = 2'd2;
    localparam t_status ST_NOID  = 2'd3;

    localparam t_cfg_idx CFG_BASE = 2'd0;
    localparam t_cfg_idx CFG_SIZE = 2'd1;
    localparam t_cfg_idx CFG_THR  = 2'd2;

    localparam t_cfg_data RST_BASE = 16'd1000;
    localparam t_cfg_data RST_SIZE = 16'd1024;
    localparam t_cfg_data RST_THR  = 16'd5;

endpackage

/* design/vpa_hole_cell.sv */
// One hole table entry with its stage of the hole search chain.
module vpa_hole_cell #(
    parameter int IDX = 0,
    parameter int AW  = 16,
    parameter int IW  = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_clear,
    input  logic [AW-1:0]  i_base,
    input  logic [AW-1:0]  i_size,
    input  logic           i_wr_en,
    input  logic [IW-1:0]  i_wr_idx,
    input  logic [AW-1:0]  i_wr_addr,
    input  logic [AW-1:0]  i_wr_len,
    input  logic           i_wr_valid,
    input  vpa_pkg::t_op   i_mode,
    input  logic [AW-1:0]  i_req,
    input  logic [AW-1:0]  i_a,
    input  logic [AW-1:0]  i_apl,
    input  logic           i_pick_f,
    input  logic [IW-1:0]  i_pick_idx,
    input  logic [AW-1:0]  i_pick_len,
    input  logic [AW-1:0]  i_pick_addr,
    input  logic           i_top_f,
    input  logic [IW-1:0]  i_top_idx,
    input  logic [AW-1:0]  i_top_addr,
    input  logic [AW-1:0]  i_top_len,
    input  logic           i_bot_f,
    input  logic [IW-1:0]  i_bot_idx,
    input  logic [AW-1:0]  i_bot_len,
    input  logic           i_emp_f,
    input  logic [IW-1:0]  i_emp_idx,
    output logic           o_pick_f,
    output logic [IW-1:0]  o_pick_idx,
    output logic [AW-1:0]  o_pick_len,
    output logic [AW-1:0]  o_pick_addr,
    output logic           o_top_f,
    output logic [IW-1:0]  o_top_idx,
    output logic [AW-1:0]  o_top_addr,
    output logic [AW-1:0]  o_top_len,
    output logic           o_bot_f,
    output logic [IW-1:0]  o_bot_idx,
    output logic [AW-1:0]  o_bot_len,
    output logic           o_emp_f,
    output logic [IW-1:0]  o_emp_idx
);
    import vpa_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    logic          r_valid;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_len;
    logic          w_fits;
    logic          w_better;
    logic          w_take;
    logic [AW-1:0] w_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_clear) begin
            r_valid <= (IDX == 0);
            r_addr  <= (IDX == 0) ? i_base : '0;
            r_len   <= (IDX == 0) ? i_size : '0;
        end else if (i_wr_en && i_wr_idx == MY_IDX) begin
            r_valid <= i_wr_valid;
            r_addr  <= i_wr_addr;
            r_len   <= i_wr_len;
        end
    end

    always_comb begin
        w_fits = r_valid && (r_len >= i_req);
        case (i_mode)
            OP_BEST:  w_better = r_len < i_pick_len;
            OP_WORST: w_better = r_len > i_pick_len;
            OP_FIRST: w_better = r_addr < i_pick_addr;
            default:  w_better = 1'b0;
        endcase
        w_take = w_fits && (!i_pick_f || w_better);
        w_end  = r_addr + r_len;
    end

    // Pass the running search results on to the next cell.
    always_ff @(posedge i_clk) begin
        o_pick_f    <= i_pick_f || w_take;
        o_pick_idx  <= w_take ? MY_IDX : i_pick_idx;
        o_pick_len  <= w_take ? r_len : i_pick_len;
        o_pick_addr <= w_take ? r_addr : i_pick_addr;
        if (!i_top_f && r_valid && w_end == i_a) begin
            o_top_f    <= 1'b1;
            o_top_idx  <= MY_IDX;
            o_top_addr <= r_addr;
            o_top_len  <= r_len;
        end else begin
            o_top_f    <= i_top_f;
            o_top_idx  <= i_top_idx;
            o_top_addr <= i_top_addr;
            o_top_len  <= i_top_len;
        end
        if (!i_bot_f && r_valid && i_apl == r_addr) begin
            o_bot_f   <= 1'b1;
            o_bot_idx <= MY_IDX;
            o_bot_len <= r_len;
        end else begin
            o_bot_f   <= i_bot_f;
            o_bot_idx <= i_bot_idx;
            o_bot_len <= i_bot_len;
        end
        o_emp_f   <= i_emp_f || !r_valid;
        o_emp_idx <= (!i_emp_f && !r_valid) ? MY_IDX : i_emp_idx;
    end

endmodule

/* design/vpa_alloc_cell.sv */
// One allocation table entry with its stage of the owner search chain.
module vpa_alloc_cell #(
    parameter int IDX = 0,
    parameter int AW  = 16,
    parameter int IW  = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_clear,
    input  logic             i_wr_en,
    input  logic [IW-1:0]    i_wr_idx,
    input  vpa_pkg::t_owner  i_wr_owner,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [AW-1:0]    i_wr_len,
    input  vpa_pkg::t_owner  i_key,
    input  logic             i_emp_f,
    input  logic [IW-1:0]    i_emp_idx,
    input  logic             i_id_f,
    input  logic [IW-1:0]    i_id_idx,
    input  logic [AW-1:0]    i_id_addr,
    input  logic [AW-1:0]    i_id_len,
    output logic             o_emp_f,
    output logic [IW-1:0]    o_emp_idx,
    output logic             o_id_f,
    output logic [IW-1:0]    o_id_idx,
    output logic [AW-1:0]    o_id_addr,
    output logic [AW-1:0]    o_id_len
);
    import vpa_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(IDX);

    t_owner        r_owner;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_len;
    logic          w_empty;
    logic          w_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_owner <= '0;
        end else if (i_wr_en && i_wr_idx == MY_IDX) begin
            r_owner <= i_wr_owner;
            r_addr  <= i_wr_addr;
            r_len   <= i_wr_len;
        end
    end

    assign w_empty = (r_owner == '0);
    assign w_hit   = !i_id_f && !w_empty && (r_owner == i_key);

    always_ff @(posedge i_clk) begin
        o_emp_f   <= i_emp_f || w_empty;
        o_emp_idx <= (!i_emp_f && w_empty) ? MY_IDX : i_emp_idx;
        o_id_f    <= i_id_f || w_hit;
        o_id_idx  <= w_hit ? MY_IDX : i_id_idx;
        o_id_addr <= w_hit ? r_addr : i_id_addr;
        o_id_len  <= w_hit ? r_len : i_id_len;
    end

endmodule

/* design/variable_partition_allocator_unit.sv */
// Top level of the variable partition allocator (best, worst, first fit and free).
// An allocation runs the hole pass, then the allocation pass; a free runs them in reverse.
// An allocation with no fitting hole ends after the hole pass, a free of an unknown id after
// the allocation pass; a free joining holes on both sides adds S_MERGE; owner zero is refused
// from idle without a pass. Throughput: one item at a time, set by the two token passes.
// Reset and base or size register writes reload both tables; busy is high then.
module variable_partition_allocator_unit #(
    parameter int HOLE_ENTRIES  = 16,
    parameter int ALLOC_ENTRIES = 16,
    parameter int ADDR_WIDTH    = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  vpa_pkg::t_op           i_operation,
    input  vpa_pkg::t_owner        i_owner_id,
    input  logic [15:0]            i_request_len,
    output logic                   o_strobe,
    output vpa_pkg::t_status       o_status,
    output vpa_pkg::t_owner        o_owner_out,
    output logic [ADDR_WIDTH-1:0]  o_block_addr,
    output logic [ADDR_WIDTH-1:0]  o_block_len,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  vpa_pkg::t_cfg_idx      i_cfg_index,
    input  vpa_pkg::t_cfg_data     i_cfg_data
);
    import vpa_pkg::*;

    localparam int AW   = ADDR_WIDTH;
    localparam int HIW  = $clog2(HOLE_ENTRIES);
    localparam int AIW  = (ALLOC_ENTRIES > 1) ? $clog2(ALLOC_ENTRIES) : 1;
    localparam int MAXE = (HOLE_ENTRIES > ALLOC_ENTRIES) ? HOLE_ENTRIES : ALLOC_ENTRIES;
    localparam int CW   = $clog2(MAXE + 1);

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_HSCAN = 2'd1;
    localparam logic [1:0] S_ASCAN = 2'd2;
    localparam logic [1:0] S_MERGE = 2'd3;

    // Pool registers and the reload request.
    logic [AW-1:0] r_base, r_size;
    logic [15:0]   r_thr;
    logic          r_clear;

    // Item being worked on.
    logic [1:0]     r_state, n_state;
    logic [CW-1:0]  r_cnt, n_cnt;
    t_op            r_op, n_op;
    t_owner         r_owner, n_owner;
    logic [AW-1:0]  r_req, n_req;
    logic [AW-1:0]  r_a, n_a;
    logic [AW-1:0]  r_l, n_l;
    logic [AW-1:0]  r_apl, n_apl;
    logic [AIW-1:0] r_id_idx, n_id_idx;
    logic [HIW-1:0] r_pick_idx, n_pick_idx;
    logic [AW-1:0]  r_pick_len, n_pick_len;
    logic [AW-1:0]  r_pick_addr, n_pick_addr;
    logic [HIW-1:0] r_fix_idx, n_fix_idx;

    // Result registers.
    logic          r_out_vld, n_out_vld;
    t_status       r_status, n_status;
    t_owner        r_own_o, n_own_o;
    logic [AW-1:0] r_baddr, n_baddr;
    logic [AW-1:0] r_blen, n_blen;

    // Table write ports, broadcast to every cell.
    logic           h_wr_en, h_wr_valid;
    logic [HIW-1:0] h_wr_idx;
    logic [AW-1:0]  h_wr_addr, h_wr_len;
    logic           a_wr_en;
    logic [AIW-1:0] a_wr_idx;
    t_owner         a_wr_owner;
    logic [AW-1:0]  a_wr_addr, a_wr_len;

    // Hole chain links; link 0 is the empty token, the last link is the answer.
    logic           h_pick_f   [0:HOLE_ENTRIES];
    logic [HIW-1:0] h_pick_idx [0:HOLE_ENTRIES];
    logic [AW-1:0]  h_pick_len [0:HOLE_ENTRIES];
    logic [AW-1:0]  h_pick_addr[0:HOLE_ENTRIES];
    logic           h_top_f    [0:HOLE_ENTRIES];
    logic [HIW-1:0] h_top_idx  [0:HOLE_ENTRIES];
    logic [AW-1:0]  h_top_addr [0:HOLE_ENTRIES];
    logic [AW-1:0]  h_top_len  [0:HOLE_ENTRIES];
    logic           h_bot_f    [0:HOLE_ENTRIES];
    logic [HIW-1:0] h_bot_idx  [0:HOLE_ENTRIES];
    logic [AW-1:0]  h_bot_len  [0:HOLE_ENTRIES];
    logic           h_emp_f    [0:HOLE_ENTRIES];
    logic [HIW-1:0] h_emp_idx  [0:HOLE_ENTRIES];

    // Allocation chain links.
    logic           a_emp_f    [0:ALLOC_ENTRIES];
    logic [AIW-1:0] a_emp_idx  [0:ALLOC_ENTRIES];
    logic           a_id_f     [0:ALLOC_ENTRIES];
    logic [AIW-1:0] a_id_idx   [0:ALLOC_ENTRIES];
    logic [AW-1:0]  a_id_addr  [0:ALLOC_ENTRIES];
    logic [AW-1:0]  a_id_len   [0:ALLOC_ENTRIES];

    // Free and allocation path decisions, and the configuration write enable.
    logic           w_bot_eff;
    logic [AW-1:0]  w_diff;
    logic           w_whole;
    logic           w_cfg_we;

    // Feed an empty token into the head of each chain.
    assign h_pick_f[0]    = 1'b0;
    assign h_pick_idx[0]  = '0;
    assign h_pick_len[0]  = '0;
    assign h_pick_addr[0] = '0;
    assign h_top_f[0]     = 1'b0;
    assign h_top_idx[0]   = '0;
    assign h_top_addr[0]  = '0;
    assign h_top_len[0]   = '0;
    assign h_bot_f[0]     = 1'b0;
    assign h_bot_idx[0]   = '0;
    assign h_bot_len[0]   = '0;
    assign h_emp_f[0]     = 1'b0;
    assign h_emp_idx[0]   = '0;
    assign a_emp_f[0]     = 1'b0;
    assign a_emp_idx[0]   = '0;
    assign a_id_f[0]      = 1'b0;
    assign a_id_idx[0]    = '0;
    assign a_id_addr[0]   = '0;
    assign a_id_len[0]    = '0;

    for (genvar g = 0; g < HOLE_ENTRIES; g++) begin : g_hole
        vpa_hole_cell #(.IDX(g), .AW(AW), .IW(HIW)) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_clear     (r_clear),
            .i_base      (r_base),
            .i_size      (r_size),
            .i_wr_en     (h_wr_en),
            .i_wr_idx    (h_wr_idx),
            .i_wr_addr   (h_wr_addr),
            .i_wr_len    (h_wr_len),
            .i_wr_valid  (h_wr_valid),
            .i_mode      (r_op),
            .i_req       (r_req),
            .i_a         (r_a),
            .i_apl       (r_apl),
            .i_pick_f    (h_pick_f[g]),
            .i_pick_idx  (h_pick_idx[g]),
            .i_pick_len  (h_pick_len[g]),
            .i_pick_addr (h_pick_addr[g]),
            .i_top_f     (h_top_f[g]),
            .i_top_idx   (h_top_idx[g]),
            .i_top_addr  (h_top_addr[g]),
            .i_top_len   (h_top_len[g]),
            .i_bot_f     (h_bot_f[g]),
            .i_bot_idx   (h_bot_idx[g]),
            .i_bot_len   (h_bot_len[g]),
            .i_emp_f     (h_emp_f[g]),
            .i_emp_idx   (h_emp_idx[g]),
            .o_pick_f    (h_pick_f[g+1]),
            .o_pick_idx  (h_pick_idx[g+1]),
            .o_pick_len  (h_pick_len[g+1]),
            .o_pick_addr (h_pick_addr[g+1]),
            .o_top_f     (h_top_f[g+1]),
            .o_top_idx   (h_top_idx[g+1]),
            .o_top_addr  (h_top_addr[g+1]),
            .o_top_len   (h_top_len[g+1]),
            .o_bot_f     (h_bot_f[g+1]),
            .o_bot_idx   (h_bot_idx[g+1]),
            .o_bot_len   (h_bot_len[g+1]),
            .o_emp_f     (h_emp_f[g+1]),
            .o_emp_idx   (h_emp_idx[g+1])
        );
    end

    for (genvar g = 0; g < ALLOC_ENTRIES; g++) begin : g_alloc
        vpa_alloc_cell #(.IDX(g), .AW(AW), .IW(AIW)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_clear    (r_clear),
            .i_wr_en    (a_wr_en),
            .i_wr_idx   (a_wr_idx),
            .i_wr_owner (a_wr_owner),
            .i_wr_addr  (a_wr_addr),
            .i_wr_len   (a_wr_len),
            .i_key      (r_owner),
            .i_emp_f    (a_emp_f[g]),
            .i_emp_idx  (a_emp_idx[g]),
            .i_id_f     (a_id_f[g]),
            .i_id_idx   (a_id_idx[g]),
            .i_id_addr  (a_id_addr[g]),
            .i_id_len   (a_id_len[g]),
            .o_emp_f    (a_emp_f[g+1]),
            .o_emp_idx  (a_emp_idx[g+1]),
            .o_id_f     (a_id_f[g+1]),
            .o_id_idx   (a_id_idx[g+1]),
            .o_id_addr  (a_id_addr[g+1]),
            .o_id_len   (a_id_len[g+1])
        );
    end

    // Configuration: always ready; a base or size write triggers a table reload next cycle.
    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= AW'(RST_BASE);
            r_size  <= AW'(RST_SIZE);
            r_thr   <= RST_THR;
            r_clear <= 1'b1;
        end else begin
            r_clear <= 1'b0;
            if (w_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_BASE: begin
                        r_base  <= AW'(i_cfg_data);
                        r_clear <= 1'b1;
                    end
                    CFG_SIZE: begin
                        r_size  <= AW'(i_cfg_data);
                        r_clear <= 1'b1;
                    end
                    CFG_THR:  r_thr <= i_cfg_data;
                    default:  ;
                endcase
            end
        end
    end

    assign busy = (r_state != S_IDLE) || r_clear;

    // A zero-length neighbour can match on both sides; join it once, as the hole above.
    assign w_bot_eff = h_bot_f[HOLE_ENTRIES] &&
                       !(h_top_f[HOLE_ENTRIES] &&
                         h_bot_idx[HOLE_ENTRIES] == h_top_idx[HOLE_ENTRIES]);
    assign w_diff    = r_pick_len - r_req;
    assign w_whole   = 32'(w_diff) <= 32'(r_thr);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt + 1'b1;
        n_op        = r_op;
        n_owner     = r_owner;
        n_req       = r_req;
        n_a         = r_a;
        n_l         = r_l;
        n_apl       = r_apl;
        n_id_idx    = r_id_idx;
        n_pick_idx  = r_pick_idx;
        n_pick_len  = r_pick_len;
        n_pick_addr = r_pick_addr;
        n_fix_idx   = r_fix_idx;
        n_out_vld   = 1'b0;
        n_status    = r_status;
        n_own_o     = r_own_o;
        n_baddr     = r_baddr;
        n_blen      = r_blen;
        h_wr_en     = 1'b0;
        h_wr_idx    = '0;
        h_wr_addr   = '0;
        h_wr_len    = '0;
        h_wr_valid  = 1'b0;
        a_wr_en     = 1'b0;
        a_wr_idx    = '0;
        a_wr_owner  = '0;
        a_wr_addr   = '0;
        a_wr_len    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (start && !busy) begin
                    n_op    = i_operation;
                    n_owner = i_owner_id;
                    n_req   = AW'(i_request_len);
                    n_cnt   = '0;
                    if (i_owner_id == '0) begin
                        // Owner zero marks an empty slot: refuse at once.
                        n_out_vld = 1'b1;
                        n_status  = ST_NOID;
                        n_own_o   = '0;
                        n_baddr   = '0;
                        n_blen    = '0;
                    end else if (i_operation == OP_FREE) begin
                        n_state = S_ASCAN;
                    end else begin
                        n_state = S_HSCAN;
                    end
                end
            end

            S_HSCAN: begin
                if (r_cnt == CW'(HOLE_ENTRIES)) begin
                    n_cnt = '0;
                    if (r_op != OP_FREE) begin
                        if (!h_pick_f[HOLE_ENTRIES]) begin
                            n_state   = S_IDLE;
                            n_out_vld = 1'b1;
                            n_status  = ST_NOFIT;
                            n_own_o   = '0;
                            n_baddr   = '0;
                            n_blen    = '0;
                        end else begin
                            n_pick_idx  = h_pick_idx[HOLE_ENTRIES];
                            n_pick_len  = h_pick_len[HOLE_ENTRIES];
                            n_pick_addr = h_pick_addr[HOLE_ENTRIES];
                            n_state     = S_ASCAN;
                        end
                    end else begin
                        // Free: join the hole above, the hole below, or take a spare slot.
                        n_state   = S_IDLE;
                        n_out_vld = 1'b1;
                        n_status  = ST_OK;
                        n_own_o   = r_owner;
                        n_baddr   = r_a;
                        n_blen    = r_l;
                        a_wr_idx  = r_id_idx;
                        a_wr_addr = r_a;
                        a_wr_len  = r_l;
                        h_wr_valid = 1'b1;
                        if (h_top_f[HOLE_ENTRIES]) begin
                            h_wr_en   = 1'b1;
                            a_wr_en   = 1'b1;
                            h_wr_idx  = h_top_idx[HOLE_ENTRIES];
                            h_wr_addr = h_top_addr[HOLE_ENTRIES];
                            h_wr_len  = h_top_len[HOLE_ENTRIES] + r_l +
                                        (w_bot_eff ? h_bot_len[HOLE_ENTRIES] : '0);
                            if (w_bot_eff) begin
                                // Drop the swallowed hole below in the S_MERGE state.
                                n_fix_idx = h_bot_idx[HOLE_ENTRIES];
                                n_state   = S_MERGE;
                                n_out_vld = 1'b0;
                            end
                        end else if (h_bot_f[HOLE_ENTRIES]) begin
                            h_wr_en   = 1'b1;
                            a_wr_en   = 1'b1;
                            h_wr_idx  = h_bot_idx[HOLE_ENTRIES];
                            h_wr_addr = r_a;
                            h_wr_len  = h_bot_len[HOLE_ENTRIES] + r_l;
                        end else if (h_emp_f[HOLE_ENTRIES]) begin
                            h_wr_en   = 1'b1;
                            a_wr_en   = 1'b1;
                            h_wr_idx  = h_emp_idx[HOLE_ENTRIES];
                            h_wr_addr = r_a;
                            h_wr_len  = r_l;
                        end else begin
                            n_status = ST_FULL;
                            n_own_o  = '0;
                            n_baddr  = '0;
                            n_blen   = '0;
                        end
                    end
                end
            end

            S_ASCAN: begin
                if (r_cnt == CW'(ALLOC_ENTRIES)) begin
                    n_cnt = '0;
                    if (r_op == OP_FREE) begin
                        if (!a_id_f[ALLOC_ENTRIES]) begin
                            n_state   = S_IDLE;
                            n_out_vld = 1'b1;
                            n_status  = ST_NOID;
                            n_own_o   = '0;
                            n_baddr   = '0;
                            n_blen    = '0;
                        end else begin
                            n_id_idx = a_id_idx[ALLOC_ENTRIES];
                            n_a      = a_id_addr[ALLOC_ENTRIES];
                            n_l      = a_id_len[ALLOC_ENTRIES];
                            n_apl    = a_id_addr[ALLOC_ENTRIES] + a_id_len[ALLOC_ENTRIES];
                            n_state  = S_HSCAN;
                        end
                    end else begin
                        n_state   = S_IDLE;
                        n_out_vld = 1'b1;
                        if (!a_emp_f[ALLOC_ENTRIES]) begin
                            n_status = ST_FULL;
                            n_own_o  = '0;
                            n_baddr  = '0;
                            n_blen   = '0;
                        end else begin
                            // Give the hole whole, or carve from its low end.
                            h_wr_en    = 1'b1;
                            h_wr_idx   = r_pick_idx;
                            h_wr_valid = !w_whole;
                            h_wr_addr  = r_pick_addr + r_req;
                            h_wr_len   = w_diff;
                            a_wr_en    = 1'b1;
                            a_wr_idx   = a_emp_idx[ALLOC_ENTRIES];
                            a_wr_owner = r_owner;
                            a_wr_addr  = r_pick_addr;
                            a_wr_len   = w_whole ? r_pick_len : r_req;
                            n_status   = ST_OK;
                            n_own_o    = r_owner;
                            n_baddr    = r_pick_addr;
                            n_blen     = w_whole ? r_pick_len : r_req;
                        end
                    end
                end
            end

            S_MERGE: begin
                h_wr_en   = 1'b1;
                h_wr_idx  = r_fix_idx;
                n_state   = S_IDLE;
                n_out_vld = 1'b1;
            end

            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op        <= n_op;
        r_owner     <= n_owner;
        r_req       <= n_req;
        r_a         <= n_a;
        r_l         <= n_l;
        r_apl       <= n_apl;
        r_id_idx    <= n_id_idx;
        r_pick_idx  <= n_pick_idx;
        r_pick_len  <= n_pick_len;
        r_pick_addr <= n_pick_addr;
        r_fix_idx   <= n_fix_idx;
        r_status    <= n_status;
        r_own_o     <= n_own_o;
        r_baddr     <= n_baddr;
        r_blen      <= n_blen;
    end

    assign o_strobe     = r_out_vld;
    assign o_status     = r_status;
    assign o_owner_out  = r_own_o;
    assign o_block_addr = r_baddr;
    assign o_block_len  = r_blen;

endmodule

/* design/vpa_checker.sv */
// Port-level checker of the allocator, bound to its top level.
`include "assert_macros.svh"

module vpa_checker #(
    parameter int ADDR_WIDTH = 16
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   start,
    input logic                   busy,
    input logic                   o_strobe,
    input vpa_pkg::t_status       o_status,
    input vpa_pkg::t_owner        o_owner_out,
    input logic [ADDR_WIDTH-1:0]  o_block_addr,
    input logic [ADDR_WIDTH-1:0]  o_block_len
);
    import vpa_pkg::*;

    logic w_fail;
    logic w_ok;
    logic w_take;
    logic w_no_pay;

    assign w_fail   = o_strobe && (o_status != ST_OK);
    assign w_ok     = o_strobe && (o_status == ST_OK);
    assign w_take   = start && !busy;
    assign w_no_pay = (o_owner_out == '0) && (o_block_addr == '0) && (o_block_len == '0);

    `VPA_ASSERT(a_fail_zero, i_clk, i_rst_n, w_fail |-> w_no_pay, "failed item carries payload")
    `VPA_ASSERT(a_ok_owner, i_clk, i_rst_n, w_ok |-> (o_owner_out != '0), "item without owner")
    `VPA_ASSERT(a_accept_busy, i_clk, i_rst_n, w_take |=> (busy || o_strobe), "item dropped")
    `VPA_ASSERT_ALWAYS(a_reset_reload, i_clk, !i_rst_n |=> busy, "no reload after reset")

endmodule

bind variable_partition_allocator_unit vpa_checker #(.ADDR_WIDTH(ADDR_WIDTH)) u_vpa_checker (.*);
